// ----- hdl/irfe_pkg.sv -----
// Shared package of the image rotate/flip engine: default sizes,
// register indexes, mode and command codes, and the queue control struct.
// No dependencies.
package irfe_pkg;

   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_CHANNELS = 3;

   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 3 * CHAN_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd2;

   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 8'd128;

   localparam logic [1:0] MODE_ROT_LEFT = 2'd0;
   localparam logic [1:0] MODE_HFLIP    = 2'd1;
   localparam logic [1:0] MODE_VFLIP    = 2'd2;
   localparam logic [1:0] MODE_PASS     = 2'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic is_read;
      logic frame_end;
   } op_ctl_type;

endpackage

// ----- hdl/irfe_queue.sv -----
// Small register FIFO used between the front and back ends and as the
// response buffer. Depends on nothing.
module irfe_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output logic [WIDTH-1:0]           head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/irfe_front.sv -----
// Front end of the image rotate/flip engine: configuration registers,
// raster counters and frame store address generation. Uses irfe_pkg.
module irfe_front #(
   parameter int MAX_ROWS = irfe_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = irfe_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [irfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [irfe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_accept,
   input  logic                                req_cmd,
   output irfe_pkg::op_ctl_type                op_ctl,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] op_addr
);

   import irfe_pkg::*;

   localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int SIZE_W  = $clog2(MAX_DIM + 1);
   localparam int CMP_W   = (SIZE_W > CSR_DATA_W) ? SIZE_W : CSR_DATA_W;
   localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);

   logic [1:0]            mode_ff, mode_in;
   logic [CSR_DATA_W-1:0] rows_ff, rows_in;
   logic [CSR_DATA_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0]      wr_row_ff, wr_row_in, wr_col_ff, wr_col_in;
   logic [CNT_W-1:0]      rd_row_ff, rd_row_in, rd_col_ff, rd_col_in;

   logic             csr_hit;
   logic [CMP_W-1:0] rows_eff, cols_eff, orows, ocols;
   logic [CMP_W-1:0] wr_row_nx, wr_col_nx, rd_row_nx, rd_col_nx;
   logic [CMP_W-1:0] src_row, src_col;
   logic             rd_col_last, rd_row_last;

   always_comb begin
      rows_eff = CMP_W'(rows_ff);
      if (rows_eff == '0) begin
         rows_eff = CMP_W'(1);
      end else if (rows_eff > CMP_W'(MAX_ROWS)) begin
         rows_eff = CMP_W'(MAX_ROWS);
      end
      cols_eff = CMP_W'(cols_ff);
      if (cols_eff == '0) begin
         cols_eff = CMP_W'(1);
      end else if (cols_eff > CMP_W'(MAX_COLS)) begin
         cols_eff = CMP_W'(MAX_COLS);
      end
   end

   // map output raster position to source pixel
   always_comb begin
      orows   = rows_eff;
      ocols   = cols_eff;
      src_row = CMP_W'(rd_row_ff);
      src_col = CMP_W'(rd_col_ff);
      case (mode_ff)
         MODE_ROT_LEFT: begin
            orows   = cols_eff;
            ocols   = rows_eff;
            src_row = CMP_W'(rd_col_ff);
            src_col = cols_eff - 1'b1 - CMP_W'(rd_row_ff);
         end
         MODE_HFLIP: begin
            src_col = cols_eff - 1'b1 - CMP_W'(rd_col_ff);
         end
         MODE_VFLIP: begin
            src_row = rows_eff - 1'b1 - CMP_W'(rd_row_ff);
         end
         default: begin
         end
      endcase
   end

   assign wr_row_nx   = CMP_W'(wr_row_ff) + 1'b1;
   assign wr_col_nx   = CMP_W'(wr_col_ff) + 1'b1;
   assign rd_row_nx   = CMP_W'(rd_row_ff) + 1'b1;
   assign rd_col_nx   = CMP_W'(rd_col_ff) + 1'b1;
   assign rd_col_last = (rd_col_nx >= ocols);
   assign rd_row_last = (rd_row_nx >= orows);

   always_comb begin
      op_ctl.is_read   = (req_cmd == CMD_READ);
      op_ctl.frame_end = rd_row_last && rd_col_last;
      if (req_cmd == CMD_READ) begin
         op_addr = ADDR_W'(src_row[CNT_W-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(src_col[CNT_W-1:0]);
      end else begin
         op_addr = ADDR_W'(wr_row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(wr_col_ff);
      end
   end

   assign csr_hit = csr_we && ((csr_index == CSR_MODE) || (csr_index == CSR_ROWS)
                               || (csr_index == CSR_COLS));

   always_comb begin
      mode_in   = mode_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      wr_row_in = wr_row_ff;
      wr_col_in = wr_col_ff;
      rd_row_in = rd_row_ff;
      rd_col_in = rd_col_ff;
      if (csr_hit) begin
         case (csr_index)
            CSR_MODE: mode_in = csr_wdata[1:0];
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default: begin
            end
         endcase
         // any register write restarts the frame
         wr_row_in = '0;
         wr_col_in = '0;
         rd_row_in = '0;
         rd_col_in = '0;
      end else if (req_accept && (req_cmd == CMD_WRITE)) begin
         if (wr_col_nx >= cols_eff) begin
            wr_col_in = '0;
            wr_row_in = (wr_row_nx >= rows_eff) ? '0 : wr_row_nx[CNT_W-1:0];
         end else begin
            wr_col_in = wr_col_nx[CNT_W-1:0];
         end
      end else if (req_accept) begin
         if (rd_col_last) begin
            rd_col_in = '0;
            rd_row_in = rd_row_last ? '0 : rd_row_nx[CNT_W-1:0];
         end else begin
            rd_col_in = rd_col_nx[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ROT_LEFT;
         rows_ff   <= SIZE_RESET;
         cols_ff   <= SIZE_RESET;
         wr_row_ff <= '0;
         wr_col_ff <= '0;
         rd_row_ff <= '0;
         rd_col_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         wr_row_ff <= wr_row_in;
         wr_col_ff <= wr_col_in;
         rd_row_ff <= rd_row_in;
         rd_col_ff <= rd_col_in;
      end
   end

endmodule

// ----- hdl/irfe_back.sv -----
// Back end of the image rotate/flip engine: frame store memory, read
// pipeline and response buffer. Uses irfe_pkg and irfe_queue.
module irfe_back #(
   parameter int MAX_ROWS = irfe_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = irfe_pkg::DEF_MAX_COLS,
   parameter int CHANNELS = irfe_pkg::DEF_CHANNELS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 op_valid,
   input  irfe_pkg::op_ctl_type                 op_ctl,
   input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] op_addr,
   input  logic [irfe_pkg::PIXEL_W-1:0]         op_pixel,
   output logic                                 op_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [irfe_pkg::PIXEL_W-1:0]         rsp_pixel,
   output logic                                 rsp_frame_end
);

   import irfe_pkg::*;

   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int STORED_CH = (CHANNELS < 3) ? CHANNELS : 3;
   localparam int STORE_W   = STORED_CH * CHAN_W;
   localparam int OQ_DEPTH  = 2;
   localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

   logic [STORE_W-1:0] mem_ff [DEPTH];
   logic [STORE_W-1:0] rd_data_ff;
   logic               rd_pend_ff, rd_pend_in;
   logic               end_pend_ff;

   logic                take, credit_ok, do_read, do_write;
   logic [OQ_CNT_W-1:0] oq_count;
   logic [OQ_CNT_W:0]   oq_load;

   assign take = rsp_valid && !rsp_stall;

   // hold a read until the response buffer has room for its data
   assign oq_load   = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(rd_pend_ff)
                      - (OQ_CNT_W + 1)'(take);
   assign credit_ok = (oq_load <= (OQ_CNT_W + 1)'(OQ_DEPTH - 1));
   assign do_read   = op_valid && op_ctl.is_read && credit_ok;
   assign do_write  = op_valid && !op_ctl.is_read;
   assign op_pop    = do_read || do_write;
   assign rd_pend_in = do_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[op_addr] <= op_pixel[STORE_W-1:0];
      end
      if (do_read) begin
         rd_data_ff  <= mem_ff[op_addr];
         end_pend_ff <= op_ctl.frame_end;
      end
   end

   irfe_queue #(
      .WIDTH (PIXEL_W + 1),
      .DEPTH (OQ_DEPTH)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rd_pend_ff),
      .push_data  ({end_pend_ff, PIXEL_W'(rd_data_ff)}),
      .full       (),
      .pop        (take),
      .head_valid (rsp_valid),
      .head_data  ({rsp_frame_end, rsp_pixel}),
      .count      (oq_count)
   );

endmodule

// ----- hdl/image_rotate_flip_engine.sv -----
// Image rotate/flip engine: loads a frame in raster order, reads it back
// rotated left, mirrored horizontally, mirrored vertically or unchanged (pass mode).
// Throughput: one request per cycle while req_stall is low, set by the single frame store port.
// A read request's response passes through the request queue, the registered memory read
// and the response buffer before it is valid.
// Reset clears counters and queues, mode 0, size 128x128; store not cleared.
module image_rotate_flip_engine #(
   parameter int MAX_ROWS = irfe_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = irfe_pkg::DEF_MAX_COLS,
   parameter int CHANNELS = irfe_pkg::DEF_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [irfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irfe_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [irfe_pkg::CHAN_W-1:0]     req_in_red,
   input  logic [irfe_pkg::CHAN_W-1:0]     req_in_green,
   input  logic [irfe_pkg::CHAN_W-1:0]     req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [irfe_pkg::CHAN_W-1:0]     rsp_out_red,
   output logic [irfe_pkg::CHAN_W-1:0]     rsp_out_green,
   output logic [irfe_pkg::CHAN_W-1:0]     rsp_out_blue,
   output logic                            rsp_frame_end
);

   import irfe_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
   localparam int CTL_W   = $bits(op_ctl_type);
   localparam int ENTRY_W = CTL_W + ADDR_W + PIXEL_W;

   logic               req_accept, cq_full, cq_valid, cq_pop;
   op_ctl_type         fe_ctl, cq_ctl;
   logic [ADDR_W-1:0]  fe_addr, cq_addr;
   logic [PIXEL_W-1:0] cq_pixel, rsp_pixel;
   logic [ENTRY_W-1:0] cq_head;

   assign req_stall  = cq_full;
   assign req_accept = req_valid && !cq_full;

   irfe_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_cmd    (req_cmd),
      .op_ctl     (fe_ctl),
      .op_addr    (fe_addr)
   );

   irfe_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_data  ({fe_ctl, fe_addr, req_in_blue, req_in_green, req_in_red}),
      .full       (cq_full),
      .pop        (cq_pop),
      .head_valid (cq_valid),
      .head_data  (cq_head),
      .count      ()
   );

   assign cq_ctl   = cq_head[ENTRY_W-1 -: CTL_W];
   assign cq_addr  = cq_head[PIXEL_W +: ADDR_W];
   assign cq_pixel = cq_head[PIXEL_W-1:0];

   irfe_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (cq_valid),
      .op_ctl        (cq_ctl),
      .op_addr       (cq_addr),
      .op_pixel      (cq_pixel),
      .op_pop        (cq_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel     (rsp_pixel),
      .rsp_frame_end (rsp_frame_end)
   );

   assign rsp_out_red   = rsp_pixel[0*CHAN_W +: CHAN_W];
   assign rsp_out_green = rsp_pixel[1*CHAN_W +: CHAN_W];
   assign rsp_out_blue  = rsp_pixel[2*CHAN_W +: CHAN_W];

endmodule
